@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the RTL module of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// The consequent holds at the same edge as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds at the edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/srde_pkg.sv @@
// ----------------------------------------------------------------------------
// srde_pkg
// Types, constants and helper functions of the signed radix digit emitter.
// ----------------------------------------------------------------------------
package srde_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_BASE_DEF   = 16;

    localparam int ALPHA_W     = 64;
    localparam int ALPHA_CHARS = 16;
    localparam int BASE_W      = 5;
    localparam int CHAR_W      = 8;
    localparam int CHUNK_W     = 8;
    localparam int CFG_IDX_W   = 2;

    typedef logic [CHAR_W-1:0] t_char;

    localparam t_char MINUS_CHAR = 8'h2D;
    localparam t_char PLUS_CHAR  = 8'h2B;

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SIZE  = 2'd2;

    function automatic t_char alpha_char(input logic [ALPHA_W-1:0] lo,
                                         input logic [ALPHA_W-1:0] hi,
                                         input logic [3:0] idx);
        logic [2*ALPHA_W-1:0] a;
        a = {hi, lo};
        return a[{idx, 3'b000} +: CHAR_W];
    endfunction

    function automatic logic alphabet_ok(input logic [ALPHA_W-1:0] lo,
                                         input logic [ALPHA_W-1:0] hi,
                                         input logic [BASE_W-1:0] base,
                                         input logic [BASE_W-1:0] max_base);
        logic  ok;
        t_char ci;
        ok = (base >= BASE_W'(2)) && (base <= max_base);
        for (int i = 0; i < ALPHA_CHARS; i++) begin
            ci = alpha_char(lo, hi, 4'(i));
            if (BASE_W'(i) < base) begin
                if (ci == PLUS_CHAR || ci == MINUS_CHAR) begin
                    ok = 1'b0;
                end
                for (int j = i + 1; j < ALPHA_CHARS; j++) begin
                    if (BASE_W'(j) < base && alpha_char(lo, hi, 4'(j)) == ci) begin
                        ok = 1'b0;
                    end
                end
            end
        end
        return ok;
    endfunction

endpackage

@@ hdl/srde_ram.sv @@
// ----------------------------------------------------------------------------
// srde_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module srde_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/signed_radix_digit_emitter_unit.sv @@
// ----------------------------------------------------------------------------
// signed_radix_digit_emitter_unit
// Renders a signed number as text in a configured radix, most significant
// digit first, with a leading minus sign for negative numbers.
//
//   channel  direction  handshake                 payload
//   input    in         i_valid / o_ready         i_number
//   output   out        o_valid / i_ready         o_character, o_last
//   config   in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each digit is found in the shared remainder unit, which handles eight
// dividend bits per cycle. Each character then takes a digit buffer read
// and a load of the output register; a minus sign takes only the load.
// Reset is synchronous and active low; no clearing pass is needed.
// A stalled output holds the sequencer until the output register is free.
// ----------------------------------------------------------------------------
module signed_radix_digit_emitter_unit #(
    parameter int VALUE_BITS = srde_pkg::VALUE_BITS_DEF,
    parameter int MAX_BASE   = srde_pkg::MAX_BASE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [VALUE_BITS-1:0]    i_number,
    output logic                            o_valid,
    input  logic                            i_ready,
    output srde_pkg::t_char                 o_character,
    output logic                            o_last,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [srde_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srde_pkg::ALPHA_W-1:0]    i_cfg_data
);

    import srde_pkg::*;

    `include "assert_macros.svh"

    localparam int STEPS = (VALUE_BITS + CHUNK_W - 1) / CHUNK_W;
    localparam int MAG_W = STEPS * CHUNK_W;
    localparam int SC_W  = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int CNT_W = $clog2(VALUE_BITS + 1);
    localparam int AW    = $clog2(VALUE_BITS);
    localparam int DW    = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_SIGN = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_WR   = 3'd4;

    logic [ALPHA_W-1:0] r_alpha_lo, r_alpha_hi;
    logic [BASE_W-1:0]  r_base;
    logic               r_alpha_ok;
    logic               r_cfg_hold;

    logic [2:0]       r_state, n_state;
    logic             r_neg, n_neg;
    logic [MAG_W-1:0] r_mag, n_mag;
    logic [DW-1:0]    r_rem, n_rem;
    logic [SC_W-1:0]  r_step, n_step;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    t_char            r_char, n_char;
    logic             r_last, n_last;

    logic                  in_acc;
    logic                  out_free;
    logic [CHUNK_W-1:0]    q_bits;
    logic [DW-1:0]         rem_fin;
    logic [BASE_W-1:0]     t_ext;
    logic [VALUE_BITS-1:0] mag_in;
    logic [MAG_W-1:0]      mag_shift;
    logic                  ram_we;
    logic [AW-1:0]         ram_raddr;
    logic [DW-1:0]         ram_q;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE) && !r_cfg_hold;
    assign in_acc      = i_valid && o_ready;
    assign out_free    = !r_out_valid || i_ready;
    assign o_valid     = r_out_valid;
    assign o_character = r_char;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_lo <= '0;
            r_alpha_hi <= '0;
            r_base     <= '0;
            r_alpha_ok <= 1'b0;
            r_cfg_hold <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ALPHA_LOW:  r_alpha_lo <= i_cfg_data;
                    CFG_ALPHA_HIGH: r_alpha_hi <= i_cfg_data;
                    CFG_BASE_SIZE:  r_base     <= i_cfg_data[BASE_W-1:0];
                    default: begin
                    end
                endcase
            end
            r_cfg_hold <= i_cfg_valid;
            r_alpha_ok <= alphabet_ok(r_alpha_lo, r_alpha_hi, r_base, BASE_W'(MAX_BASE));
        end
    end

    // Eight restoring steps of the shared remainder unit on the top chunk.
    always_comb begin
        rem_fin = r_rem;
        q_bits  = '0;
        t_ext   = '0;
        for (int b = CHUNK_W - 1; b >= 0; b--) begin
            t_ext = BASE_W'({rem_fin, r_mag[MAG_W - CHUNK_W + b]});
            if (t_ext >= r_base) begin
                t_ext     = t_ext - r_base;
                q_bits[b] = 1'b1;
            end
            rem_fin = t_ext[DW-1:0];
        end
        mag_shift = (r_mag << CHUNK_W) | MAG_W'(q_bits);
    end

    assign mag_in = i_number[VALUE_BITS-1] ? (~i_number + 1'b1) : i_number;

    always_comb begin
        n_state     = r_state;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_rem       = r_rem;
        n_step      = r_step;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_ready;
        n_char      = r_char;
        n_last      = r_last;
        ram_we      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && r_alpha_ok) begin
                    n_neg   = i_number[VALUE_BITS-1];
                    n_mag   = MAG_W'(mag_in);
                    n_rem   = '0;
                    n_step  = '0;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_mag = mag_shift;
                n_rem = rem_fin;
                if (r_step == SC_W'(STEPS - 1)) begin
                    ram_we = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                    n_rem  = '0;
                    n_step = '0;
                    if (mag_shift == '0 || n_cnt >= CNT_W'(VALUE_BITS)) begin
                        n_state = r_neg ? ST_SIGN : ST_RD;
                    end
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_SIGN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = MINUS_CHAR;
                    n_last      = 1'b0;
                    n_state     = ST_RD;
                end
            end
            ST_RD: begin
                n_state = ST_WR;
            end
            ST_WR: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_char      = alpha_char(r_alpha_lo, r_alpha_hi, 4'(ram_q));
                    n_last      = (r_cnt == CNT_W'(1));
                    n_cnt       = r_cnt - 1'b1;
                    n_state     = (r_cnt == CNT_W'(1)) ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
            r_step      <= '0;
            r_neg       <= 1'b0;
            r_mag       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
            r_step      <= n_step;
            r_neg       <= n_neg;
            r_mag       <= n_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign ram_raddr = AW'(r_cnt - 1'b1);

    srde_ram #(
        .WIDTH (DW),
        .DEPTH (VALUE_BITS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (rem_fin),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    `ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CNT_W'(VALUE_BITS), "digit count overflow")
    `ASSERT_IMPLIES(a_emit_cnt, i_clk, i_rst_n, r_state == ST_RD || r_state == ST_WR, r_cnt != '0, "emit with no digits")
    `ASSERT_NEXT(a_last_char, i_clk, i_rst_n, r_state == ST_WR && out_free && r_cnt == CNT_W'(1), r_state == ST_IDLE && o_valid && o_last, "final character not flagged")
    `ASSERT_NEXT(a_bad_alpha, i_clk, i_rst_n, in_acc && !r_alpha_ok, r_state == ST_IDLE, "invalid alphabet started work")

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the signed radix digit emitter. A short directed
// table covers reset state, decimal, hexadecimal and binary extremes, and
// every way an alphabet can be rejected. Random phases follow, each with a
// fresh alphabet and radix. Every output word is compared with a predictor
// kept inside the bench, under random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import srde_pkg::*;

    localparam int VB            = VALUE_BITS_DEF;
    localparam int MAX_BASE      = MAX_BASE_DEF;
    localparam int SETTLE_CYCLES = 400;
    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int RANDOM_ITEMS  = 370;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [95:0]          BY_MODEL   = '0;

    typedef enum logic {ROW_REG, ROW_NUM} t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [ALPHA_W-1:0]   data;
        logic [95:0]          text;
    } t_step_row;

    typedef struct packed {
        t_char ch;
        logic  last;
    } t_char_rec;

    localparam int NUM_STEPS = 38;
    localparam t_step_row STEPS [NUM_STEPS] = '{
        '{ROW_NUM, CFG_ALPHA_LOW,  64'd42,                BY_MODEL},
        '{ROW_REG, CFG_ALPHA_LOW,  64'h3736_3534_3332_3130, BY_MODEL},
        '{ROW_REG, CFG_ALPHA_HIGH, 64'h0000_0000_0000_3938, BY_MODEL},
        '{ROW_REG, CFG_BASE_SIZE,  64'd10,                BY_MODEL},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'd0,                 96'("0")},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'd7,                 96'("7")},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'hFFFF_FFFF,         96'("-1")},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'd10,                96'("10")},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'hFFFF_FFF6,         96'("-10")},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'h7FFF_FFFF,         96'("2147483647")},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'h8000_0000,         96'("-2147483648")},
        '{ROW_REG, CFG_ALPHA_LOW,  64'h3635_3433_3231_3000, BY_MODEL},
        '{ROW_REG, CFG_ALPHA_HIGH, 64'h4645_4443_4241_3938, BY_MODEL},
        '{ROW_REG, CFG_BASE_SIZE,  64'hFFFF_FFFF_FFFF_FFF0, BY_MODEL},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'd0,                 BY_MODEL},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'hFFFF_FFFF,         BY_MODEL},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'h7FFF_FFFF,         BY_MODEL},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'h8000_0000,         BY_MODEL},
        '{ROW_REG, CFG_BASE_SIZE,  64'd2,                 BY_MODEL},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'h8000_0000,         BY_MODEL},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'h7FFF_FFFF,         BY_MODEL},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'h5555_5555,         BY_MODEL},
        '{ROW_REG, CFG_BASE_SIZE,  64'd1,                 BY_MODEL},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'd5,                 BY_MODEL},
        '{ROW_REG, CFG_BASE_SIZE,  64'd17,                BY_MODEL},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'd5,                 BY_MODEL},
        '{ROW_REG, CFG_BASE_SIZE,  64'd31,                BY_MODEL},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'd5,                 BY_MODEL},
        '{ROW_REG, CFG_UNUSED,     64'hFFFF_FFFF_FFFF_FFFF, BY_MODEL},
        '{ROW_REG, CFG_BASE_SIZE,  64'd16,                BY_MODEL},
        '{ROW_REG, CFG_ALPHA_HIGH, 64'h2D45_4443_4241_3938, BY_MODEL},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'd5,                 BY_MODEL},
        '{ROW_REG, CFG_ALPHA_HIGH, 64'h2B45_4443_4241_3938, BY_MODEL},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'd5,                 BY_MODEL},
        '{ROW_REG, CFG_ALPHA_HIGH, 64'h3145_4443_4241_3938, BY_MODEL},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'd5,                 BY_MODEL},
        '{ROW_REG, CFG_BASE_SIZE,  64'd15,                BY_MODEL},
        '{ROW_NUM, CFG_ALPHA_LOW,  64'hFFFF_FF01,         BY_MODEL}
    };

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic signed [VB-1:0] i_number    = '0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    t_char                o_character;
    logic                 o_last;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [ALPHA_W-1:0]   i_cfg_data  = '0;

    logic [ALPHA_W-1:0] cur_alpha_lo = '0;
    logic [ALPHA_W-1:0] cur_alpha_hi = '0;
    logic [BASE_W-1:0]  cur_base     = '0;

    t_char_rec pending_text [$];
    t_char_rec next_want;
    int        fails       = 0;
    int        cycles      = 0;
    int        ready_hold  = 0;
    int        random_sent = 0;
    bit        calm        = 1'b0;

    signed_radix_digit_emitter_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_number    (i_number),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_character (o_character),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 15);
        if (calm || r < 8) begin
            return 0;
        end
        if (r < 14) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic t_char glyph_at(input logic [3:0] idx);
        if (idx[3]) begin
            return cur_alpha_hi[idx[2:0]*8 +: 8];
        end
        return cur_alpha_lo[idx[2:0]*8 +: 8];
    endfunction

    function automatic bit alphabet_usable();
        t_char c;
        if (cur_base < 2 || cur_base > MAX_BASE) begin
            return 1'b0;
        end
        for (int i = 0; i < cur_base; i++) begin
            c = glyph_at(4'(i));
            if (c == PLUS_CHAR || c == MINUS_CHAR) begin
                return 1'b0;
            end
            for (int j = i + 1; j < cur_base; j++) begin
                if (glyph_at(4'(j)) == c) begin
                    return 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // Digits are taken from the unsigned magnitude, least significant first,
    // and queued most significant first.
    function automatic void render_number(input logic [VB-1:0] number);
        logic [VB-1:0] mag;
        logic [VB-1:0] radix;
        logic [3:0]    digits [VB];
        int            count;
        t_char_rec     rec;
        if (!alphabet_usable()) begin
            return;
        end
        radix = VB'(cur_base);
        mag   = number;
        if (number[VB-1]) begin
            mag      = ~number + 1'b1;
            rec.ch   = MINUS_CHAR;
            rec.last = 1'b0;
            pending_text.push_back(rec);
        end
        count = 0;
        do begin
            digits[count] = 4'(mag % radix);
            count++;
            mag = mag / radix;
        end while (mag != 0);
        for (int k = count - 1; k >= 0; k--) begin
            rec.ch   = glyph_at(digits[k]);
            rec.last = (k == 0);
            pending_text.push_back(rec);
        end
    endfunction

    function automatic void push_typed(input logic [95:0] text);
        t_char     chars [$];
        t_char_rec rec;
        for (int k = 11; k >= 0; k--) begin
            if (text[k*8 +: 8] != 8'h00) begin
                chars.push_back(text[k*8 +: 8]);
            end
        end
        foreach (chars[i]) begin
            rec.ch   = chars[i];
            rec.last = (i == chars.size() - 1);
            pending_text.push_back(rec);
        end
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [ALPHA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (index)
            CFG_ALPHA_LOW: begin
                cur_alpha_lo = data;
            end
            CFG_ALPHA_HIGH: begin
                cur_alpha_hi = data;
            end
            CFG_BASE_SIZE: begin
                cur_base = data[BASE_W-1:0];
            end
            default: begin
            end
        endcase
    endtask

    // Valid stays high after acceptance so that a back-to-back word needs
    // no lowering; a gap lowers it first.
    task automatic send_number(input logic [VB-1:0] number, input logic [95:0] text);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_number <= number;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (text != BY_MODEL) begin
            push_typed(text);
        end else begin
            render_number(number);
        end
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending_text.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic build_alphabet(input bit broken, output logic [ALPHA_W-1:0] lo,
                                  output logic [ALPHA_W-1:0] hi,
                                  output logic [BASE_W-1:0] base);
        t_char glyphs [16];
        bit    fresh;
        int    r;
        int    i;
        int    j;
        r = $urandom_range(0, 3);
        base = (r == 0) ? 5'd2 : (r == 1) ? 5'd16 : 5'($urandom_range(2, 16));
        for (int k = 0; k < 16; k++) begin
            fresh = 1'b0;
            while (!fresh) begin
                glyphs[k] = t_char'($urandom);
                fresh = (glyphs[k] != PLUS_CHAR && glyphs[k] != MINUS_CHAR);
                for (int m = 0; m < k; m++) begin
                    if (glyphs[m] == glyphs[k]) begin
                        fresh = 1'b0;
                    end
                end
            end
        end
        if (base < 16 && $urandom_range(0, 1) == 1) begin
            r = $urandom_range(0, 2);
            glyphs[$urandom_range(base, 15)] = (r == 0) ? PLUS_CHAR :
                                               (r == 1) ? MINUS_CHAR : glyphs[0];
        end
        if (broken) begin
            case ($urandom_range(0, 3))
                0: base = 5'($urandom_range(0, 1));
                1: base = 5'($urandom_range(17, 31));
                2: glyphs[$urandom_range(0, base - 1)] =
                       $urandom_range(0, 1) ? PLUS_CHAR : MINUS_CHAR;
                default: begin
                    i = $urandom_range(0, base - 2);
                    j = $urandom_range(i + 1, base - 1);
                    glyphs[j] = glyphs[i];
                end
            endcase
        end
        for (int k = 0; k < 8; k++) begin
            lo[k*8 +: 8] = glyphs[k];
            hi[k*8 +: 8] = glyphs[k+8];
        end
    endtask

    function automatic logic [VB-1:0] pick_number(input logic [BASE_W-1:0] base);
        logic [VB-1:0] v;
        logic [VB-1:0] radix;
        int            r;
        r = $urandom_range(0, 9);
        radix = (base < 2) ? VB'(2) : VB'(base);
        if (r < 4) begin
            v = VB'($urandom);
        end else if (r == 4) begin
            case ($urandom_range(0, 4))
                0: v = '0;
                1: v = '1;
                2: v = VB'(1);
                3: v = {1'b1, {(VB-1){1'b0}}};
                default: v = {1'b0, {(VB-1){1'b1}}};
            endcase
        end else if (r < 7) begin
            v = VB'($urandom_range(0, 300));
        end else if (r == 7) begin
            v = VB'(1);
            repeat ($urandom_range(0, VB - 1)) begin
                if (v <= '1 / radix) begin
                    v = v * radix;
                end
            end
            v = v + VB'($urandom_range(0, 2)) - VB'(1);
        end else begin
            v = VB'($urandom) >> $urandom_range(0, VB - 1);
        end
        if (r >= 5 && $urandom_range(0, 1) == 1) begin
            v = ~v + 1'b1;
        end
        return v;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_text.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual character %h last %b",
                         $time, o_character, o_last);
                fails++;
            end else begin
                next_want = pending_text.pop_front();
                if (o_character !== next_want.ch) begin
                    $display("%0t: character mismatch, expected %h, actual %h",
                             $time, next_want.ch, o_character);
                    fails++;
                end
                if (o_last !== next_want.last) begin
                    $display("%0t: last mismatch, expected %b, actual %b",
                             $time, next_want.last, o_last);
                    fails++;
                end
            end
        end
        if (ready_hold > 0) begin
            i_ready <= 1'b0;
            ready_hold = ready_hold - 1;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                ready_hold = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [ALPHA_W-1:0] lo;
        logic [ALPHA_W-1:0] hi;
        logic [BASE_W-1:0]  base;
        bit                 broken;
        int                 count;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < NUM_STEPS; r++) begin
            if (STEPS[r].kind == ROW_REG) begin
                if (r > 0 && STEPS[r-1].kind == ROW_NUM) begin
                    settle();
                end
                write_reg(STEPS[r].index, STEPS[r].data);
            end else begin
                i_cfg_valid <= 1'b0;
                send_number(STEPS[r].data[VB-1:0], STEPS[r].text);
            end
        end

        while (random_sent < RANDOM_ITEMS) begin
            settle();
            calm   = ($urandom_range(0, 4) == 0);
            broken = ($urandom_range(0, 5) == 0);
            build_alphabet(broken, lo, hi, base);
            write_reg(CFG_ALPHA_LOW, lo);
            if ($urandom_range(0, 7) == 0) begin
                write_reg(CFG_UNUSED, {$urandom, $urandom});
            end
            write_reg(CFG_ALPHA_HIGH, hi);
            write_reg(CFG_BASE_SIZE, {$urandom, 27'($urandom), base});
            i_cfg_valid <= 1'b0;
            count = broken ? $urandom_range(1, 3) : $urandom_range(5, 25);
            repeat (count) begin
                send_number(pick_number(base), BY_MODEL);
                if (!broken) begin
                    random_sent++;
                end
            end
        end
        settle();

        if (fails == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ signed_radix_digit_emitter_unit.f @@
+incdir+hdl
hdl/srde_pkg.sv
hdl/srde_ram.sv
hdl/signed_radix_digit_emitter_unit.sv
bench/testbench.sv
